/* rtl/core/acx_pkg.sv */
package acx_pkg;

  localparam int unsigned InstrBits           = 12;
  localparam int unsigned PcBits              = 10;
  localparam int unsigned DataBits            = 8;
  localparam int unsigned DataAddrBitsDefault = 8;

  // Major opcode, instruction bits 11:10.
  localparam logic [1:0] MajJc  = 2'b00;
  localparam logic [1:0] MajJz  = 2'b01;
  localparam logic [1:0] MajImm = 2'b10;
  localparam logic [1:0] MajReg = 2'b11;

  // Immediate group, instruction bits 9:8.
  localparam logic [1:0] ImmLd  = 2'b00;
  localparam logic [1:0] ImmAdc = 2'b01;
  localparam logic [1:0] ImmAdx = 2'b10;
  localparam logic [1:0] ImmRet = 2'b11;

  // Register and indexed group, instruction bits 9:7.
  localparam logic [2:0] RegLd  = 3'b000;
  localparam logic [2:0] RegSt  = 3'b001;
  localparam logic [2:0] RegTax = 3'b010;
  localparam logic [2:0] RegTxa = 3'b011;
  localparam logic [2:0] RegAdd = 3'b100;
  localparam logic [2:0] RegSub = 3'b101;
  localparam logic [2:0] RegAnd = 3'b110;
  localparam logic [2:0] RegNor = 3'b111;

  typedef struct packed {
    logic [PcBits-1:0]   pc;
    logic [DataBits-1:0] acc;
    logic                carry;
    logic                zero;
    logic [DataBits-1:0] idx;
    logic [PcBits-1:0]   ret;
  } arch_state_t;

  typedef struct packed {
    logic                en;
    logic [DataBits-1:0] addr;
    logic [DataBits-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic [PcBits-1:0]   next_pc;
    logic [DataBits-1:0] acc_value;
    logic                carry_flag;
    logic                zero_flag;
    logic [DataBits-1:0] index_value;
    logic                store_done;
    logic [DataBits-1:0] store_addr;
    logic [DataBits-1:0] store_data;
  } result_t;

endpackage

/* rtl/core/acx_if.sv */
interface acx_instr_if;
  logic                            valid;
  logic                            ready;
  logic [acx_pkg::InstrBits-1:0]   instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface acx_result_if;
  logic                           valid;
  logic                           ready;
  logic [acx_pkg::PcBits-1:0]     next_pc;
  logic [acx_pkg::DataBits-1:0]   acc_value;
  logic                           carry_flag;
  logic                           zero_flag;
  logic [acx_pkg::DataBits-1:0]   index_value;
  logic                           store_done;
  logic [acx_pkg::DataBits-1:0]   store_addr;
  logic [acx_pkg::DataBits-1:0]   store_data;

  modport source (
    output valid, output next_pc, output acc_value, output carry_flag,
    output zero_flag, output index_value, output store_done,
    output store_addr, output store_data, input ready
  );
  modport sink (
    input valid, input next_pc, input acc_value, input carry_flag,
    input zero_flag, input index_value, input store_done,
    input store_addr, input store_data, output ready
  );
endinterface

/* rtl/core/acx_dstore.sv */
module acx_dstore #(
  parameter int unsigned ADDR_BITS = acx_pkg::DataAddrBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ADDR_BITS-1:0]          rd_addr_i,
  input  acx_pkg::store_wr_t            wr_i,
  output logic [acx_pkg::DataBits-1:0]  rd_data_o
);
  import acx_pkg::*;

  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic [DataBits-1:0] mem_q [Depth];
  logic [Depth-1:0]    valid_q;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [DataBits-1:0] rd_raw_q;
  logic                rd_vld_q;
  logic                hit_q;
  logic [DataBits-1:0] hit_data_q;

  assign wr_addr = wr_i.addr[ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    rd_raw_q   <= mem_q[rd_addr_i];
    hit_data_q <= wr_i.data;
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
      hit_q    <= wr_i.en && (wr_addr == rd_addr_i);
    end
  end

  // A write at the same edge as the read is forwarded to the read data.
  assign rd_data_o = hit_q    ? hit_data_q :
                     rd_vld_q ? rd_raw_q   : '0;

endmodule

/* rtl/core/acx_exec.sv */
module acx_exec #(
  parameter int unsigned ADDR_BITS = acx_pkg::DataAddrBitsDefault
) (
  input  logic [acx_pkg::InstrBits-1:0] instr_i,
  input  acx_pkg::arch_state_t          state_i,
  input  logic [acx_pkg::DataBits-1:0]  mem_data_i,
  output acx_pkg::arch_state_t          state_o,
  output acx_pkg::store_wr_t            store_o
);
  import acx_pkg::*;

  logic [DataBits-1:0] imm;
  logic [DataBits-1:0] dmask;
  logic [DataBits:0]   adc_imm;
  logic [DataBits:0]   add_mem;
  logic [DataBits:0]   sub_mem;
  logic [PcBits-1:0]   pc_base;
  logic                take;

  assign imm     = instr_i[DataBits-1:0];
  assign dmask   = DataBits'(state_i.idx[ADDR_BITS-1:0]);
  assign adc_imm = {1'b0, state_i.acc} + {1'b0, imm} + (DataBits+1)'(state_i.carry);
  assign add_mem = {1'b0, state_i.acc} + {1'b0, mem_data_i}
                 + (DataBits+1)'(state_i.carry);
  assign sub_mem = {1'b0, state_i.acc} - {1'b0, mem_data_i}
                 - (DataBits+1)'(state_i.carry);
  assign take    = instr_i[10] ? state_i.zero : state_i.carry;

  always_comb begin
    state_o       = state_i;
    pc_base       = state_i.pc;
    store_o.en    = 1'b0;
    store_o.addr  = '0;
    store_o.data  = '0;
    unique case (instr_i[11:10])
      MajJc, MajJz: begin
        if (take) begin
          state_o.ret = state_i.pc;
          pc_base     = instr_i[PcBits-1:0];
        end
      end
      MajImm: begin
        unique case (instr_i[9:8])
          ImmLd: begin
            state_o.acc   = imm;
            state_o.carry = 1'b0;
          end
          ImmAdc: begin
            state_o.acc   = adc_imm[DataBits-1:0];
            state_o.carry = adc_imm[DataBits];
          end
          ImmAdx: begin
            state_o.idx = state_i.idx + imm;
          end
          default: begin
            state_o.acc   = imm;
            state_o.carry = 1'b0;
            pc_base       = state_i.ret;
          end
        endcase
      end
      default: begin
        unique case (instr_i[9:7])
          RegLd: begin
            state_o.acc   = mem_data_i;
            state_o.carry = 1'b0;
          end
          RegSt: begin
            store_o.en   = 1'b1;
            store_o.addr = dmask;
            store_o.data = state_i.acc;
          end
          RegTax: begin
            state_o.idx = state_i.acc;
          end
          RegTxa: begin
            state_o.acc   = state_i.idx;
            state_o.carry = 1'b0;
          end
          RegAdd: begin
            state_o.acc   = add_mem[DataBits-1:0];
            state_o.carry = add_mem[DataBits];
          end
          RegSub: begin
            state_o.acc   = sub_mem[DataBits-1:0];
            state_o.carry = sub_mem[DataBits];
          end
          RegAnd: begin
            state_o.acc   = state_i.acc & mem_data_i;
            state_o.carry = 1'b0;
          end
          default: begin
            state_o.acc   = ~(state_i.acc | mem_data_i);
            state_o.carry = 1'b0;
          end
        endcase
      end
    endcase
    state_o.pc   = pc_base + PcBits'(1);
    state_o.zero = (state_o.acc == '0) && !state_o.carry;
  end

endmodule

/* rtl/core/accumulator_cpu_execute_step.sv */
// Executes one 12-bit instruction per item on a small accumulator machine with
// an 8-bit accumulator and carry, an 8-bit index register, a 10-bit program
// counter, a one-deep return register and a data store of 2**DATA_ADDR_BITS
// bytes that reads as zero after reset. Each accepted instruction yields one
// result item carrying the program counter, accumulator, flags and index after
// the step, plus the address and byte of any store (both zero otherwise). An
// instruction is executed while it sits in the input register and its result
// is captured in the result register when it retires, and one item is taken
// every cycle while the result side keeps up. The rate is set by the data
// store read port: its registered read is always aimed at the index value
// that the next instruction will use, with a write at the same address
// forwarded. No clearing pass is needed after reset; a valid bit per byte
// stands in.
module accumulator_cpu_execute_step #(
  parameter int unsigned DATA_ADDR_BITS = acx_pkg::DataAddrBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acx_instr_if.sink    in_i,
  acx_result_if.source out_o
);
  import acx_pkg::*;

  // Input register: holds one instruction waiting for execution.
  logic [InstrBits-1:0] instr_q;
  logic                 in_vld_q;

  // Architectural state, updated only when an instruction retires.
  arch_state_t state_q;
  arch_state_t state_exec;
  arch_state_t state_d;

  store_wr_t            store_exec;
  store_wr_t            store_wr;
  logic [DataBits-1:0]  mem_data;

  // Result register.
  result_t res_q;
  logic    out_vld_q;

  logic advance;

  // An instruction retires when it is present and the result register is
  // free or being emptied in this cycle.
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      instr_q <= in_i.instruction;
    end
  end

  acx_exec #(
    .ADDR_BITS (DATA_ADDR_BITS)
  ) u_exec (
    .instr_i    (instr_q),
    .state_i    (state_q),
    .mem_data_i (mem_data),
    .state_o    (state_exec),
    .store_o    (store_exec)
  );

  assign state_d = advance ? state_exec : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // The store is written only when the store instruction actually retires.
  always_comb begin
    store_wr    = store_exec;
    store_wr.en = store_exec.en && advance;
  end

  // The read address is the index that the next executed instruction will
  // see, so its registered read data is ready in time for it.
  acx_dstore #(
    .ADDR_BITS (DATA_ADDR_BITS)
  ) u_dstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (state_d.idx[DATA_ADDR_BITS-1:0]),
    .wr_i      (store_wr),
    .rd_data_o (mem_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.next_pc     <= state_exec.pc;
      res_q.acc_value   <= state_exec.acc;
      res_q.carry_flag  <= state_exec.carry;
      res_q.zero_flag   <= state_exec.zero;
      res_q.index_value <= state_exec.idx;
      res_q.store_done  <= store_exec.en;
      res_q.store_addr  <= store_exec.addr;
      res_q.store_data  <= store_exec.data;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.next_pc     = res_q.next_pc;
  assign out_o.acc_value   = res_q.acc_value;
  assign out_o.carry_flag  = res_q.carry_flag;
  assign out_o.zero_flag   = res_q.zero_flag;
  assign out_o.index_value = res_q.index_value;
  assign out_o.store_done  = res_q.store_done;
  assign out_o.store_addr  = res_q.store_addr;
  assign out_o.store_data  = res_q.store_data;

endmodule

/* verif/accumulator_cpu_execute_step_tb.sv */
module accumulator_cpu_execute_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acx_pkg::*;

  // Size of the data store in the instance below, and the mask that the index
  // register goes through before it addresses the store.
  localparam int unsigned AddrBits = DataAddrBitsDefault;
  localparam int unsigned StoreDepth = 1 << AddrBits;
  localparam logic [DataBits-1:0] AddrMask = DataBits'(StoreDepth - 1);

  // Roughly how many instructions the whole run executes.
  localparam int unsigned NumItems = 1450;
  // Items accepted before the idling pattern moves on to its next phase.
  localparam int unsigned PhaseLen = 500;
  // Cycles without any handshake on either side before the run is abandoned.
  // Neither side idles with a chance above 66 percent, so a run of this
  // length without progress can only mean a hung block.
  localparam int unsigned StallLimit = 5000;
  // Cycles allowed after the last result, covering the input and result registers.
  localparam int unsigned DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  acx_instr_if  instr_if ();
  acx_result_if result_if ();

  accumulator_cpu_execute_step u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_if),
    .out_o  (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Instruction words waiting to be offered, and the results that the
  // accepted ones must produce, oldest first.
  logic [InstrBits-1:0] pending_instrs[$];
  result_t              expected_results[$];

  // Architectural state as the testbench believes it to be.
  logic [PcBits-1:0]   cpu_pc;
  logic [DataBits-1:0] cpu_acc;
  logic                cpu_carry;
  logic                cpu_zero;
  logic [DataBits-1:0] cpu_index;
  logic [PcBits-1:0]   cpu_ret;
  logic [DataBits-1:0] cpu_mem [StoreDepth];

  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned jumps_taken = 0;
  int unsigned returns_done = 0;
  int unsigned stores_done = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  result_t exp_res;
  result_t step_res;

  // The sender idles lightly while the receiver idles heavily at first, then
  // the other way round, and in the last phase neither side holds back so
  // that back-to-back throughput is exercised as well.
  always_comb begin
    if (items_accepted < PhaseLen) begin
      send_idle_pct = 38;
      recv_idle_pct = 66;
    end else if (items_accepted < 2 * PhaseLen) begin
      send_idle_pct = 66;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic logic [InstrBits-1:0] imm_word(logic [1:0] op, logic [7:0] val);
    return {MajImm, op, val};
  endfunction

  function automatic logic [InstrBits-1:0] reg_word(logic [2:0] op, logic [6:0] spare);
    return {MajReg, op, spare};
  endfunction

  function automatic logic [InstrBits-1:0] jump_word(logic [1:0] cond,
                                                     logic [PcBits-1:0] target);
    return {cond, target};
  endfunction

  // Executes one instruction against the testbench's copy of the machine and
  // returns the result item that the block should produce for it.
  task automatic exec_instruction(input logic [InstrBits-1:0] word, output result_t res);
    logic [DataBits-1:0] addr;
    logic [DataBits-1:0] operand;
    logic [9:0]          sum;
    logic                taken;
    begin
      addr    = cpu_index & AddrMask;
      operand = cpu_mem[addr];
      res     = '0;
      case (word[11:10])
        MajJc, MajJz: begin
          // Both jumps look at the flags left by the previous instruction.
          taken = (word[11:10] == MajJz) ? cpu_zero : cpu_carry;
          if (taken) begin
            cpu_ret = cpu_pc;
            cpu_pc  = word[PcBits-1:0];
            jumps_taken++;
          end
        end
        MajImm: begin
          case (word[9:8])
            ImmLd: begin
              cpu_acc   = word[7:0];
              cpu_carry = 1'b0;
            end
            ImmAdc: begin
              sum       = {2'b00, cpu_acc} + {2'b00, word[7:0]} + {9'd0, cpu_carry};
              cpu_acc   = sum[7:0];
              cpu_carry = sum[8];
            end
            ImmAdx: cpu_index = cpu_index + word[7:0];
            ImmRet: begin
              cpu_acc   = word[7:0];
              cpu_carry = 1'b0;
              cpu_pc    = cpu_ret;
              returns_done++;
            end
            default: ;
          endcase
        end
        default: begin
          case (word[9:7])
            RegLd: begin
              cpu_acc   = operand;
              cpu_carry = 1'b0;
            end
            RegSt: begin
              cpu_mem[addr]   = cpu_acc;
              res.store_done = 1'b1;
              res.store_addr = addr;
              res.store_data = cpu_acc;
              stores_done++;
            end
            RegTax: cpu_index = cpu_acc;
            RegTxa: begin
              cpu_acc   = cpu_index;
              cpu_carry = 1'b0;
            end
            RegAdd: begin
              sum       = {2'b00, cpu_acc} + {2'b00, operand} + {9'd0, cpu_carry};
              cpu_acc   = sum[7:0];
              cpu_carry = sum[8];
            end
            RegSub: begin
              // A borrow wraps the difference, which leaves bit 8 set.
              sum       = {2'b00, cpu_acc} - {2'b00, operand} - {9'd0, cpu_carry};
              cpu_acc   = sum[7:0];
              cpu_carry = sum[8];
            end
            RegAnd: begin
              cpu_acc   = cpu_acc & operand;
              cpu_carry = 1'b0;
            end
            default: begin
              cpu_acc   = ~(cpu_acc | operand);
              cpu_carry = 1'b0;
            end
          endcase
        end
      endcase
      // Every instruction, a taken jump or a return included, steps the PC.
      cpu_pc   = cpu_pc + 1'b1;
      cpu_zero = (cpu_acc == '0) && !cpu_carry;
      res.next_pc     = cpu_pc;
      res.acc_value   = cpu_acc;
      res.carry_flag  = cpu_carry;
      res.zero_flag   = cpu_zero;
      res.index_value = cpu_index;
    end
  endtask

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endfunction

  // Driver. An instruction is predicted at the edge where it is accepted; the
  // valid line is only changed once the current item has gone or none is
  // being offered, so an offered item is never withdrawn.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_if.valid       <= 1'b0;
      instr_if.instruction <= '0;
    end else begin
      if (instr_if.valid && instr_if.ready) begin
        exec_instruction(instr_if.instruction, step_res);
        expected_results.push_back(step_res);
        items_accepted <= items_accepted + 1;
      end
      if (!instr_if.valid || instr_if.ready) begin
        if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          instr_if.valid       <= 1'b1;
          instr_if.instruction <= pending_instrs.pop_front();
        end else begin
          instr_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result is matched against the oldest expectation;
  // the ready line is redrawn on each cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no instruction outstanding");
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("next_pc", exp_res.next_pc, result_if.next_pc);
          check_field("acc_value", exp_res.acc_value, result_if.acc_value);
          check_field("carry_flag", exp_res.carry_flag, result_if.carry_flag);
          check_field("zero_flag", exp_res.zero_flag, result_if.zero_flag);
          check_field("index_value", exp_res.index_value, result_if.index_value);
          check_field("store_done", exp_res.store_done, result_if.store_done);
          check_field("store_addr", exp_res.store_addr, result_if.store_addr);
          check_field("store_data", exp_res.store_data, result_if.store_data);
        end
        results_checked <= results_checked + 1;
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((instr_if.valid && instr_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(negedge clk_i);
    $display("FAIL accumulator_cpu_execute_step");
    $finish;
  end

  initial begin
    int unsigned pick;
    instr_if.valid       = 1'b0;
    instr_if.instruction = '0;
    result_if.ready      = 1'b0;

    cpu_pc    = '0;
    cpu_acc   = '0;
    cpu_carry = 1'b0;
    cpu_zero  = 1'b0;
    cpu_index = '0;
    cpu_ret   = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;

    // Directed opening. The carry out of an immediate add feeds a taken
    // carry jump to the top address, so the PC wraps to zero; a store at
    // index zero follows while carry is still set. Then a taken zero jump and
    // a return to the saved address, the index wrapping both ways, a store
    // and reload at the top of the store, and each indexed arithmetic form, the
    // add and both subtracts with carry in, a borrow included. Unused low bits are
    // set in some register forms to show that they are ignored.
    pending_instrs.push_back(imm_word(ImmLd, 8'hFF));
    pending_instrs.push_back(imm_word(ImmAdc, 8'h01));
    pending_instrs.push_back(jump_word(MajJc, 10'h3FF));
    pending_instrs.push_back(jump_word(MajJz, 10'h200));
    pending_instrs.push_back(reg_word(RegSt, 7'h7F));
    pending_instrs.push_back(imm_word(ImmLd, 8'h00));
    pending_instrs.push_back(jump_word(MajJc, 10'h123));
    pending_instrs.push_back(jump_word(MajJz, 10'h155));
    pending_instrs.push_back(imm_word(ImmRet, 8'hAA));
    pending_instrs.push_back(imm_word(ImmAdx, 8'hFF));
    pending_instrs.push_back(reg_word(RegSt, 7'h00));
    pending_instrs.push_back(imm_word(ImmAdx, 8'h01));
    pending_instrs.push_back(reg_word(RegTxa, 7'h00));
    pending_instrs.push_back(imm_word(ImmAdx, 8'hFF));
    pending_instrs.push_back(reg_word(RegLd, 7'h00));
    pending_instrs.push_back(reg_word(RegTax, 7'h7F));
    pending_instrs.push_back(imm_word(ImmLd, 8'h55));
    pending_instrs.push_back(reg_word(RegSt, 7'h00));
    pending_instrs.push_back(imm_word(ImmLd, 8'hFF));
    pending_instrs.push_back(imm_word(ImmAdc, 8'hFF));
    pending_instrs.push_back(reg_word(RegAdd, 7'h00));
    pending_instrs.push_back(reg_word(RegSub, 7'h00));
    pending_instrs.push_back(reg_word(RegSub, 7'h7F));
    pending_instrs.push_back(reg_word(RegAnd, 7'h00));
    pending_instrs.push_back(reg_word(RegNor, 7'h7F));

    // Random part. Most traffic is arithmetic and register work so that the
    // flags change often enough for jumps to be taken. Now and then the index
    // is pinned to a small window, so that stores and later loads meet at the
    // same addresses instead of scattering over the whole store.
    while (pending_instrs.size() < NumItems) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        pending_instrs.push_back(jump_word($urandom_range(1) ? MajJz : MajJc,
                                           PcBits'($urandom)));
      end else if (pick < 40) begin
        pending_instrs.push_back(imm_word(2'($urandom), 8'($urandom)));
      end else if (pick < 50) begin
        pending_instrs.push_back(imm_word(ImmLd, 8'($urandom_range(15))));
        pending_instrs.push_back(reg_word(RegTax, 7'($urandom)));
      end else begin
        pending_instrs.push_back(reg_word(3'($urandom), 7'($urandom)));
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every instruction to be taken and every result to be seen,
    // then give the pipeline time to show any stray extra result.
    while (pending_instrs.size() != 0 || instr_if.valid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Executed %0d instructions and checked %0d results under three idling phases.",
             items_accepted, results_checked);
    $display("Jumps taken: %0d, returns: %0d, stores: %0d.",
             jumps_taken, returns_done, stores_done);
    if (mismatches == 0) begin
      $display("PASS accumulator_cpu_execute_step");
    end else begin
      $display("FAIL accumulator_cpu_execute_step");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/acx_pkg.sv
rtl/core/acx_if.sv
rtl/core/acx_dstore.sv
rtl/core/acx_exec.sv
rtl/core/accumulator_cpu_execute_step.sv
verif/accumulator_cpu_execute_step_tb.sv
